### rtl/snfc_pkg.sv
`default_nettype none

package snfc_pkg;

    localparam int unsigned CNT_W   = 64;
    localparam int unsigned MAGIC_W = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 4;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // Fixed header bytes and bytes per descriptor entry (17 = 16 + 1).
    localparam logic [CNT_W-1:0] FIXED_HEAD = 64'd13;
    localparam int unsigned      DESC_SHIFT = 4;

    localparam logic [BYTE_W-1:0] FT_META     = 8'd0;
    localparam logic [BYTE_W-1:0] FT_NODES    = 8'd1;
    localparam logic [BYTE_W-1:0] FT_SESSIONS = 8'd2;

    localparam logic [BYTE_W-1:0] RST_VERSION    = 8'd8;
    localparam logic [BYTE_W-1:0] RST_MIN_CHUNKS = 8'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CHECK = 2'd1,
        PH_DONE  = 2'd2,
        PH_ERROR = 2'd3
    } phase_t;

    typedef enum logic {
        OP_HEADER = 1'b0,
        OP_DESC   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_MAGIC      = 2'd0,
        REG_VERSION    = 2'd1,
        REG_MIN_CHUNKS = 2'd2
    } reg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 4'd0,
        ST_TOO_SMALL   = 4'd1,
        ST_MAGIC       = 4'd2,
        ST_VERSION     = 4'd3,
        ST_COUNT_BIG   = 4'd4,
        ST_COUNT_SMALL = 4'd5,
        ST_BAD_TYPE    = 4'd6,
        ST_FIRST       = 4'd7,
        ST_LAST        = 4'd8,
        ST_MIDDLE      = 4'd9,
        ST_IN_HEADER   = 4'd10,
        ST_BEYOND      = 4'd11,
        ST_OVERLAP     = 4'd12,
        ST_UNEXPECTED  = 4'd13
    } status_t;

    typedef struct packed {
        logic [MAGIC_W-1:0] magic;
        logic [BYTE_W-1:0]  version;
        logic [BYTE_W-1:0]  min_chunks;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/snfc_rec_if.sv
`default_nettype none

interface snfc_rec_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [63:0] num_chunks;
    logic [63:0] buffer_size;
    logic [7:0]  frame_type;
    logic [63:0] frame_offset;
    logic [63:0] frame_size;

    modport source (
        output valid, op, magic, version, num_chunks, buffer_size,
               frame_type, frame_offset, frame_size,
        input  ready
    );
    modport sink (
        input  valid, op, magic, version, num_chunks, buffer_size,
               frame_type, frame_offset, frame_size,
        output ready
    );
endinterface

`default_nettype wire

### rtl/snfc_res_if.sv
`default_nettype none

interface snfc_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [63:0] chunk_index;
    logic        last;
    logic [63:0] header_bytes;

    modport source (
        output valid, status, chunk_index, last, header_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_index, last, header_bytes,
        output ready
    );
endinterface

`default_nettype wire

### rtl/snfc_cfg.sv
`default_nettype none

module snfc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [snfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [snfc_pkg::DATA_W-1:0]   pwdata,
    output logic      [snfc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output snfc_pkg::cfg_t                     cfg
);

    snfc_pkg::cfg_t cfg_reg;
    snfc_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                snfc_pkg::REG_MAGIC:      cfg_next.magic      = pwdata;
                snfc_pkg::REG_VERSION:    cfg_next.version    = pwdata[7:0];
                snfc_pkg::REG_MIN_CHUNKS: cfg_next.min_chunks = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            snfc_pkg::REG_MAGIC:      prdata = cfg_reg.magic;
            snfc_pkg::REG_VERSION:    prdata = {24'd0, cfg_reg.version};
            snfc_pkg::REG_MIN_CHUNKS: prdata = {24'd0, cfg_reg.min_chunks};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic      <= '0;
            cfg_reg.version    <= snfc_pkg::RST_VERSION;
            cfg_reg.min_chunks <= snfc_pkg::RST_MIN_CHUNKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/snfc_core.sv
`default_nettype none

module snfc_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire snfc_pkg::cfg_t cfg,
    snfc_rec_if.sink            rec,
    snfc_res_if.source          res
);

    // Input stage.
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [31:0] s1_magic_reg;
    logic [7:0]  s1_version_reg;
    logic [63:0] s1_count_reg;
    logic [63:0] s1_bufsz_reg;
    logic [7:0]  s1_type_reg;
    logic [63:0] s1_off_reg;
    logic [63:0] s1_size_reg;

    // Table state.
    snfc_pkg::phase_t phase_reg, phase_next;
    logic [63:0] next_index_reg, next_index_next;
    logic [63:0] count_reg, count_next;
    logic [63:0] count_m1_reg, count_m1_next;
    logic [63:0] hdr_len_reg, hdr_len_next;
    logic [63:0] buf_len_reg, buf_len_next;
    logic [63:0] last_end_reg, last_end_next;

    // Result stage.
    logic                 res_valid_reg;
    snfc_pkg::status_t    res_status_reg, res_status_next;
    logic [63:0]          res_index_reg, res_index_next;
    logic                 res_last_reg, res_last_next;
    logic [63:0]          res_hb_reg, res_hb_next;

    logic        proc;
    logic        rec_fire;
    logic        is_hdr;
    logic        in_check;
    logic [68:0] cnt_x17;
    logic [63:0] hb_w;
    logic [63:0] room_w;
    logic        hdr_too_big;
    logic [63:0] buf_left;
    logic        idx_first;
    logic        idx_final;
    logic        idx_middle;
    snfc_pkg::status_t hdr_status;
    snfc_pkg::status_t desc_status;
    snfc_pkg::status_t status_w;

    assign proc      = s1_valid_reg && (!res_valid_reg || res.ready);
    assign rec.ready = !s1_valid_reg || proc;
    assign rec_fire  = rec.valid && rec.ready;
    assign is_hdr    = (s1_op_reg == snfc_pkg::OP_HEADER);
    assign in_check  = (phase_reg == snfc_pkg::PH_CHECK);

    // count * 17 without overflow; count > (size - 13) / 17 iff 17 * count > size - 13.
    assign cnt_x17     = ({5'b00000, s1_count_reg} << snfc_pkg::DESC_SHIFT)
                         + {5'b00000, s1_count_reg};
    assign hb_w        = cnt_x17[63:0] + snfc_pkg::FIXED_HEAD;
    assign room_w      = s1_bufsz_reg - snfc_pkg::FIXED_HEAD;
    assign hdr_too_big = cnt_x17 > {5'b00000, room_w};

    assign buf_left   = buf_len_reg - s1_off_reg;
    assign idx_first  = (next_index_reg == 64'd0);
    assign idx_final  = (next_index_reg == count_m1_reg);
    assign idx_middle = !idx_first && (next_index_reg < count_m1_reg);

    // Status of the record in the input stage.
    always_comb
    begin
        if (s1_bufsz_reg < snfc_pkg::FIXED_HEAD)
            hdr_status = snfc_pkg::ST_TOO_SMALL;
        else if (s1_magic_reg != cfg.magic)
            hdr_status = snfc_pkg::ST_MAGIC;
        else if (s1_version_reg != cfg.version)
            hdr_status = snfc_pkg::ST_VERSION;
        else if (hdr_too_big)
            hdr_status = snfc_pkg::ST_COUNT_BIG;
        else if (s1_count_reg < {56'd0, cfg.min_chunks})
            hdr_status = snfc_pkg::ST_COUNT_SMALL;
        else
            hdr_status = snfc_pkg::ST_OK;

        if (s1_type_reg > snfc_pkg::FT_SESSIONS)
            desc_status = snfc_pkg::ST_BAD_TYPE;
        else if (idx_first && s1_type_reg != snfc_pkg::FT_META)
            desc_status = snfc_pkg::ST_FIRST;
        else if (idx_final && s1_type_reg != snfc_pkg::FT_SESSIONS)
            desc_status = snfc_pkg::ST_LAST;
        else if (idx_middle && s1_type_reg != snfc_pkg::FT_NODES)
            desc_status = snfc_pkg::ST_MIDDLE;
        else if (s1_off_reg < hdr_len_reg)
            desc_status = snfc_pkg::ST_IN_HEADER;
        else if (s1_off_reg > buf_len_reg || s1_size_reg > buf_left)
            desc_status = snfc_pkg::ST_BEYOND;
        else if (!idx_first && s1_off_reg < last_end_reg)
            desc_status = snfc_pkg::ST_OVERLAP;
        else
            desc_status = snfc_pkg::ST_OK;

        if (is_hdr)
            status_w = hdr_status;
        else if (in_check)
            status_w = desc_status;
        else
            status_w = snfc_pkg::ST_UNEXPECTED;
    end

    // Result fields.
    always_comb
    begin
        res_status_next = status_w;
        res_index_next  = (!is_hdr && in_check) ? next_index_reg : 64'd0;
        res_hb_next     = is_hdr ? hb_w : hdr_len_reg;
        if (status_w != snfc_pkg::ST_OK)
            res_last_next = 1'b0;
        else if (is_hdr)
            res_last_next = (s1_count_reg == 64'd0);
        else
            res_last_next = idx_final;
    end

    // Next table state.
    always_comb
    begin
        phase_next      = phase_reg;
        next_index_next = next_index_reg;
        count_next      = count_reg;
        count_m1_next   = count_m1_reg;
        hdr_len_next    = hdr_len_reg;
        buf_len_next    = buf_len_reg;
        last_end_next   = last_end_reg;
        if (proc)
        begin
            if (is_hdr)
            begin
                if (hdr_status == snfc_pkg::ST_OK)
                begin
                    count_next      = s1_count_reg;
                    count_m1_next   = s1_count_reg - 64'd1;
                    hdr_len_next    = hb_w;
                    buf_len_next    = s1_bufsz_reg;
                    last_end_next   = '0;
                    next_index_next = '0;
                    phase_next      = (s1_count_reg == 64'd0) ? snfc_pkg::PH_DONE
                                                              : snfc_pkg::PH_CHECK;
                end
                else
                begin
                    phase_next = snfc_pkg::PH_ERROR;
                end
            end
            else if (in_check)
            begin
                if (desc_status == snfc_pkg::ST_OK)
                begin
                    last_end_next   = s1_off_reg + s1_size_reg;
                    next_index_next = next_index_reg + 64'd1;
                    if (idx_final)
                        phase_next = snfc_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = snfc_pkg::PH_ERROR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            phase_reg      <= snfc_pkg::PH_IDLE;
            next_index_reg <= '0;
            count_reg      <= '0;
            count_m1_reg   <= '0;
            hdr_len_reg    <= '0;
            buf_len_reg    <= '0;
            last_end_reg   <= '0;
        end
        else
        begin
            if (rec_fire)
                s1_valid_reg <= 1'b1;
            else if (proc)
                s1_valid_reg <= 1'b0;

            if (proc)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            phase_reg      <= phase_next;
            next_index_reg <= next_index_next;
            count_reg      <= count_next;
            count_m1_reg   <= count_m1_next;
            hdr_len_reg    <= hdr_len_next;
            buf_len_reg    <= buf_len_next;
            last_end_reg   <= last_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_fire)
        begin
            s1_op_reg      <= rec.op;
            s1_magic_reg   <= rec.magic;
            s1_version_reg <= rec.version;
            s1_count_reg   <= rec.num_chunks;
            s1_bufsz_reg   <= rec.buffer_size;
            s1_type_reg    <= rec.frame_type;
            s1_off_reg     <= rec.frame_offset;
            s1_size_reg    <= rec.frame_size;
        end
        if (proc)
        begin
            res_status_reg <= res_status_next;
            res_index_reg  <= res_index_next;
            res_last_reg   <= res_last_next;
            res_hb_reg     <= res_hb_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.status       = res_status_reg;
    assign res.chunk_index  = res_index_reg;
    assign res.last         = res_last_reg;
    assign res.header_bytes = res_hb_reg;

    // Only a header beat may leave the error phase.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == snfc_pkg::PH_ERROR && proc && !is_hdr)
        |=> (phase_reg == snfc_pkg::PH_ERROR))
        else $error("error phase left without a header");

    // While checking, the descriptor index never passes the final entry.
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == snfc_pkg::PH_CHECK) |-> (next_index_reg <= count_m1_reg))
        else $error("descriptor index past final entry");

    // A completed table is only reported with a clean status.
    a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_last_reg) |-> (res_status_reg == snfc_pkg::ST_OK))
        else $error("last flagged on a failing record");

    // A record stalled behind a full result stage stays in the input stage.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !proc) |=> (s1_valid_reg && $stable(s1_off_reg)))
        else $error("input stage lost a stalled record");

    // Table state only moves when a record is processed.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> ($stable(next_index_reg) && $stable(hdr_len_reg)))
        else $error("table state changed without a record");

endmodule

`default_nettype wire

### rtl/snapshot_frame_table_checker_top.sv
// Channel  Role    Beat contents
// rec      sink    op, magic, version, num_chunks, buffer_size, frame_type,
//                  frame_offset, frame_size
// res      source  status, chunk_index, last, header_bytes
// apb      slave   expected_magic @0x0, expected_version @0x4, min_chunks @0x8
//
// Each record passes the input register and then the result register before
// its result is offered. The checks against the stored table state are
// combinational, so one record is taken per cycle while results are drained.
// A stalled result holds the input register; rec.ready drops only when both
// stages are full. Reset is asynchronous, needs no clearing pass.
`default_nettype none

module snapshot_frame_table_checker_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    snfc_rec_if.sink                           rec,
    snfc_res_if.source                         res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [snfc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [snfc_pkg::DATA_W-1:0]   pwdata,
    output logic      [snfc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    snfc_pkg::cfg_t cfg;

    snfc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    snfc_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rec   (rec),
        .res   (res)
    );

endmodule

`default_nettype wire
